// File: rtl/iee_pkg.sv
package iee_pkg;

  // default geometry: signed Q15.16
  localparam int VALUE_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 6;

  // ascii codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_BAD  = 3'd1;
  localparam logic [2:0] ST_MISS = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_OVF  = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_MUL  = 2'd1,
    PEND_DIV  = 2'd2
  } pend_e;

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      default: r = 32'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/infix_expression_evaluator.sv
// digit, point and other characters are handled in S_IDLE; the next request is taken right after
// unless it is the last; an operator or the last character runs a bit-serial number conversion
// (NW = max(VALUE_WIDTH, fraction width) + FRAC_BITS, 48 by default), then a serial multiply
// or a serial divide on the one shared divider; both are skipped when no number precedes;
// the last character then waits in S_EMIT while the result register is stalled; rst_ni
// asynchronously clears the control state, but not the multiplier, payload or divider data
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH     = iee_pkg::VALUE_WIDTH,
  parameter int FRAC_BITS       = iee_pkg::FRAC_BITS,
  parameter int MAX_FRAC_DIGITS = iee_pkg::MAX_FRAC_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             character_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [2:0]             status_o
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int IW  = W - F;                           // integer digits, one bit of headroom
  localparam int PW  = $clog2((10 ** MAX_FRAC_DIGITS) + 1);
  localparam int CW  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int DW  = (W > PW) ? W : PW;
  localparam int NW  = DW + F;
  localparam int MW  = NW + W;                          // magnitude width before saturation
  localparam int MCW = $clog2(W + 1);

  localparam logic [IW+3:0] INT_LIM = (IW+4)'({(IW-1){1'b1}});
  localparam logic [IW-1:0] INT_SAT = {1'b1, {(IW-1){1'b0}}};
  localparam logic [MW-1:0] LIM_POS = MW'({(W-1){1'b1}});
  localparam logic [MW-1:0] LIM_NEG = LIM_POS + 1'b1;
  localparam logic [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_END   = 9'b000000010,  // close the current number
    S_CDIV  = 9'b000000100,  // fraction to binary, serial divide
    S_CONV  = 9'b000001000,  // assemble number, launch term op
    S_MUL   = 9'b000010000,  // shift-add multiply
    S_DIV   = 9'b000100000,  // serial fixed-point divide
    S_OPFIN = 9'b001000000,  // saturate product or quotient into the term
    S_POST  = 9'b010000000,  // operator side effects, fold into the sum
    S_EMIT  = 9'b100000000   // hand the result to the output register
  } state_e;

  state_e           state_q, state_d;
  logic [W-1:0]     sum_q, sum_d;
  logic [W-1:0]     term_q, term_d;
  logic             neg_q, neg_d;
  iee_pkg::pend_e   pend_q, pend_d;
  logic [IW-1:0]    int_q, int_d;
  logic [PW-1:0]    frac_q, frac_d;
  logic [CW-1:0]    fcnt_q, fcnt_d;
  logic             digit_q, digit_d;
  logic             point_q, point_d;
  logic [2:0]       err_q, err_d;
  iee_pkg::op_e     kind_q, kind_d;
  logic             last_q, last_d;
  logic             phase_last_q, phase_last_d;
  logic             opsel_q, opsel_d;       // 1: divide result in S_OPFIN
  logic [MCW-1:0]   mcnt_q, mcnt_d;
  logic [W-1:0]     ma_q, ma_d;
  logic [W-1:0]     mb_q, mb_d;
  logic [2*W-1:0]   prod_q, prod_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     out_value_q;
  logic [2:0]       out_status_q;

  logic             latch_en;
  logic [2:0]       latch_code;
  logic             emit_go;
  logic             div_start;
  logic [NW-1:0]    div_dividend;
  logic [DW-1:0]    div_divisor;
  logic [NW-1:0]    div_q;
  logic             div_done;

  logic             is_digit;
  logic             is_op;
  iee_pkg::op_e     char_op;
  logic [3:0]       dval;
  logic [IW+3:0]    int_next;
  logic [PW+3:0]    frac_next;
  logic [31:0]      p_full;
  logic [PW-1:0]    p_val;
  logic [PW+F-1:0]  conv_num;
  logic [MW-1:0]    conv_m;
  logic [W:0]       conv_sat;
  logic [W-1:0]     term_abs;
  logic [MW-1:0]    op_mag;
  logic [W:0]       op_sat;
  logic [W:0]       fold_sum;
  logic             fold_ovf;
  logic [W-1:0]     fold_val;
  logic [W:0]       mul_sum;

  // saturate a magnitude with sign into the value range, msb flags overflow
  function automatic logic [W:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic [W:0] r;
    if (!neg) begin
      r = (m > LIM_POS) ? {1'b1, VMAX} : {1'b0, m[W-1:0]};
    end else begin
      r = (m > LIM_NEG) ? {1'b1, VMIN} : {1'b0, W'(~m[W-1:0] + 1'b1)};
    end
    return r;
  endfunction

  // character decode
  assign is_digit = (character_i >= iee_pkg::CH_ZERO) && (character_i <= iee_pkg::CH_NINE);
  assign dval     = 4'(character_i - iee_pkg::CH_ZERO);
  assign is_op    = (character_i == iee_pkg::CH_PLUS) || (character_i == iee_pkg::CH_MINUS) ||
                    (character_i == iee_pkg::CH_STAR) || (character_i == iee_pkg::CH_SLASH);

  always_comb begin
    priority if (character_i == iee_pkg::CH_MINUS) char_op = iee_pkg::OP_SUB;
    else if (character_i == iee_pkg::CH_STAR)      char_op = iee_pkg::OP_MUL;
    else if (character_i == iee_pkg::CH_SLASH)     char_op = iee_pkg::OP_DIV;
    else                                           char_op = iee_pkg::OP_ADD;
  end

  // decimal accumulation: x*10 + d as two shifts and adds
  assign int_next  = {int_q, 3'b000} + {2'b00, int_q, 1'b0} + (IW+4)'(dval);
  assign frac_next = {frac_q, 3'b000} + {2'b00, frac_q, 1'b0} + (PW+4)'(dval);

  // fraction to binary: round(frac * 2^F / 10^n), ties up
  assign p_full   = iee_pkg::pow10(4'(fcnt_q));
  assign p_val    = p_full[PW-1:0];
  assign conv_num = {frac_q, {F{1'b0}}} + (PW+F)'(p_val >> 1);
  assign conv_m   = (MW'(int_q) << F) + MW'(div_q);
  assign conv_sat = sat_mag(1'b0, conv_m);

  // term magnitude; numbers are never negative, so the term sign carries through
  assign term_abs = term_q[W-1] ? W'(~term_q + 1'b1) : term_q;
  assign op_mag   = opsel_q ? MW'(div_q) : MW'(prod_q >> F);
  assign op_sat   = sat_mag(term_q[W-1], op_mag);

  // saturating fold of the term into the running sum
  assign fold_sum = neg_q ? ({sum_q[W-1], sum_q} - {term_q[W-1], term_q})
                          : ({sum_q[W-1], sum_q} + {term_q[W-1], term_q});
  assign fold_ovf = fold_sum[W] != fold_sum[W-1];
  assign fold_val = fold_ovf ? (fold_sum[W] ? VMIN : VMAX) : fold_sum[W-1:0];

  // shift-add multiply step
  assign mul_sum = {1'b0, prod_q[2*W-1:W]} + (mb_q[0] ? {1'b0, ma_q} : '0);

  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    term_d       = term_q;
    neg_d        = neg_q;
    pend_d       = pend_q;
    int_d        = int_q;
    frac_d       = frac_q;
    fcnt_d       = fcnt_q;
    digit_d      = digit_q;
    point_d      = point_q;
    err_d        = err_q;
    kind_d       = kind_q;
    last_d       = last_q;
    phase_last_d = phase_last_q;
    opsel_d      = opsel_q;
    mcnt_d       = mcnt_q;
    ma_d         = ma_q;
    mb_d         = mb_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q && out_stall_i;
    latch_en     = 1'b0;
    latch_code   = iee_pkg::ST_OK;
    div_start    = 1'b0;
    div_dividend = NW'(conv_num);
    div_divisor  = DW'(p_val);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d       = last_i;
          phase_last_d = 1'b0;
          if (is_digit) begin
            if (point_q) begin
              if (fcnt_q < CW'(MAX_FRAC_DIGITS)) begin
                frac_d = frac_next[PW-1:0];
                fcnt_d = fcnt_q + 1'b1;
              end
            end else begin
              int_d = (int_next > INT_LIM) ? INT_SAT : int_next[IW-1:0];
            end
            digit_d = 1'b1;
          end else if (character_i == iee_pkg::CH_POINT) begin
            if (point_q) begin
              latch_en   = 1'b1;
              latch_code = iee_pkg::ST_BAD;
            end else begin
              point_d = 1'b1;
            end
          end else if (is_op) begin
            kind_d  = char_op;
            state_d = S_END;
          end else begin
            latch_en   = 1'b1;
            latch_code = iee_pkg::ST_BAD;
          end
          if (!is_op && last_i) begin
            phase_last_d = 1'b1;
            state_d      = S_END;
          end
        end
      end
      S_END: begin
        if (!digit_q) begin
          // operator or end with no number before it
          latch_en   = 1'b1;
          latch_code = iee_pkg::ST_MISS;
          int_d      = '0;
          frac_d     = '0;
          fcnt_d     = '0;
          point_d    = 1'b0;
          state_d    = S_POST;
        end else begin
          div_start = 1'b1;
          state_d   = S_CDIV;
        end
      end
      S_CDIV: begin
        if (div_done) state_d = S_CONV;
      end
      S_CONV: begin
        if (conv_sat[W]) begin
          latch_en   = 1'b1;
          latch_code = iee_pkg::ST_OVF;
        end
        int_d   = '0;
        frac_d  = '0;
        fcnt_d  = '0;
        digit_d = 1'b0;
        point_d = 1'b0;
        pend_d  = iee_pkg::PEND_NONE;
        unique case (pend_q)
          iee_pkg::PEND_MUL: begin
            ma_d    = term_abs;
            mb_d    = conv_sat[W-1:0];
            prod_d  = '0;
            mcnt_d  = MCW'(W);
            opsel_d = 1'b0;
            state_d = S_MUL;
          end
          iee_pkg::PEND_DIV: begin
            if (conv_sat[W-1:0] == '0) begin
              latch_en   = 1'b1;
              latch_code = iee_pkg::ST_DIV0;
              state_d    = S_POST;
            end else begin
              div_start    = 1'b1;
              div_dividend = NW'({term_abs, {F{1'b0}}});
              div_divisor  = DW'(conv_sat[W-1:0]);
              opsel_d      = 1'b1;
              state_d      = S_DIV;
            end
          end
          default: begin
            term_d  = conv_sat[W-1:0];
            state_d = S_POST;
          end
        endcase
      end
      S_MUL: begin
        prod_d = {mul_sum, prod_q[W-1:1]};
        mb_d   = mb_q >> 1;
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == MCW'(1)) state_d = S_OPFIN;
      end
      S_DIV: begin
        if (div_done) state_d = S_OPFIN;
      end
      S_OPFIN: begin
        term_d = op_sat[W-1:0];
        if (op_sat[W]) begin
          latch_en   = 1'b1;
          latch_code = iee_pkg::ST_OVF;
        end
        state_d = S_POST;
      end
      S_POST: begin
        if (phase_last_q) begin
          sum_d = fold_val;
          if (fold_ovf) begin
            latch_en   = 1'b1;
            latch_code = iee_pkg::ST_OVF;
          end
          state_d = S_EMIT;
        end else begin
          unique case (kind_q)
            iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
              sum_d = fold_val;
              if (fold_ovf) begin
                latch_en   = 1'b1;
                latch_code = iee_pkg::ST_OVF;
              end
              term_d = '0;
              neg_d  = (kind_q == iee_pkg::OP_SUB);
              pend_d = iee_pkg::PEND_NONE;
            end
            iee_pkg::OP_MUL: pend_d = iee_pkg::PEND_MUL;
            iee_pkg::OP_DIV: pend_d = iee_pkg::PEND_DIV;
          endcase
          if (last_q) begin
            phase_last_d = 1'b1;
            state_d      = S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
          sum_d        = '0;
          term_d       = '0;
          neg_d        = 1'b0;
          pend_d       = iee_pkg::PEND_NONE;
          int_d        = '0;
          frac_d       = '0;
          fcnt_d       = '0;
          digit_d      = 1'b0;
          point_d      = 1'b0;
          phase_last_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // error priority: bad, missing and divide-by-zero stick, overflow can be replaced
    if (latch_en && ((err_q == iee_pkg::ST_OK) ||
                     ((err_q == iee_pkg::ST_OVF) && (latch_code != iee_pkg::ST_OVF)))) begin
      err_d = latch_code;
    end
    if (emit_go) err_d = iee_pkg::ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      term_q       <= '0;
      neg_q        <= 1'b0;
      pend_q       <= iee_pkg::PEND_NONE;
      int_q        <= '0;
      frac_q       <= '0;
      fcnt_q       <= '0;
      digit_q      <= 1'b0;
      point_q      <= 1'b0;
      err_q        <= iee_pkg::ST_OK;
      kind_q       <= iee_pkg::OP_ADD;
      last_q       <= 1'b0;
      phase_last_q <= 1'b0;
      opsel_q      <= 1'b0;
      mcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      term_q       <= term_d;
      neg_q        <= neg_d;
      pend_q       <= pend_d;
      int_q        <= int_d;
      frac_q       <= frac_d;
      fcnt_q       <= fcnt_d;
      digit_q      <= digit_d;
      point_q      <= point_d;
      err_q        <= err_d;
      kind_q       <= kind_d;
      last_q       <= last_d;
      phase_last_q <= phase_last_d;
      opsel_q      <= opsel_d;
      mcnt_q       <= mcnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // multiplier datapath and output payload
  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    prod_q <= prod_d;
    if (emit_go) begin
      out_value_q  <= ((err_q == iee_pkg::ST_BAD) || (err_q == iee_pkg::ST_MISS) ||
                       (err_q == iee_pkg::ST_DIV0)) ? '0 : sum_q;
      out_status_q <= err_q;
    end
  end

  // shared divider: fraction conversion and fixed-point quotient
  iee_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

`ifndef SYNTHESIS
  a_div_done_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_CDIV) || (state_q == S_DIV))
    else $error("divider finished outside a divide state");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mcnt_q != '0))
    else $error("multiply running with empty bit count");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (sum_q == '0) && (err_q == iee_pkg::ST_OK) && (state_q == S_IDLE))
    else $error("state not cleared after result");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q == iee_pkg::ST_BAD) || (err_q == iee_pkg::ST_MISS) ||
     (err_q == iee_pkg::ST_DIV0)) && !emit_go |=> $stable(err_q))
    else $error("sticky error code changed");
`endif

endmodule

// File: rtl/iee_div.sv
module iee_div #(
  parameter int NW = iee_pkg::VALUE_WIDTH + iee_pkg::FRAC_BITS,
  parameter int DW = iee_pkg::VALUE_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_q, num_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule
